// ===== rtl/blr_pkg.sv =====
// Package for the line rasterizer: payload structs, register map, reset values.
// Used by every module of the block; depends on nothing.
`default_nettype none

package blr_pkg;

    localparam int COORD_BITS = 12;
    localparam int DIM_BITS   = 12;
    localparam int COLOR_BITS = 24;
    localparam int ADDR_BITS  = 22;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 24;

    localparam logic [DIM_BITS-1:0]   FRAME_WIDTH_RST  = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0]   FRAME_HEIGHT_RST = DIM_BITS'(480);
    localparam logic [COLOR_BITS-1:0] LINE_COLOR_RST   = COLOR_BITS'(24'hFFFFFF);
    localparam logic [COLOR_BITS-1:0] ALT_COLOR_RST    = COLOR_BITS'(24'hFF0000);

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_BITS-1:0]
    {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_LINE_COLOR   = 2'd2,
        REG_ALT_COLOR    = 2'd3
    } reg_idx_t;

    typedef struct packed
    {
        cmd_t                          cmd;
        logic signed [COORD_BITS-1:0]  start_x;
        logic signed [COORD_BITS-1:0]  start_y;
        logic signed [COORD_BITS-1:0]  end_x;
        logic signed [COORD_BITS-1:0]  end_y;
        logic                          use_alt_color;
    } line_in_t;

    typedef struct packed
    {
        logic                   pixel_valid;
        logic [ADDR_BITS-1:0]   pixel_address;
        logic [COLOR_BITS-1:0]  pixel_color;
        logic                   line_done;
    } pixel_out_t;

    typedef struct packed
    {
        logic [DIM_BITS-1:0]   frame_width;
        logic [DIM_BITS-1:0]   frame_height;
        logic [COLOR_BITS-1:0] line_color;
        logic [COLOR_BITS-1:0] alt_color;
    } cfg_t;

    // Pixel handed from the walker to the address stage
    typedef struct packed
    {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         none;
        logic                         done;
        logic                         sel;
    } pend_t;

endpackage

`default_nettype wire

// ===== rtl/bresenham_line_rasterizer_top.sv =====
// Top level of the midpoint line rasterizer: config registers, walker, address stage.
// Depends on blr_pkg, blr_cfg_regs, blr_walker, blr_pixel.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data): a load command sets up a line from
//   two endpoints and yields its first pixel; each step command yields the next
//   pixel. Every accepted command yields exactly one result.
//   Output channel (out_valid/out_ready/out_data): one pixel per transfer with
//   frame address, colour, an in-frame flag and a last-pixel flag.
//   Config port (cfg_we/cfg_index/cfg_data): single-cycle writes, idle time only.
//   Path: the walker's state update is registered in the pending register, then
//   the address multiply and clip in the result register.
//   Throughput: one command per cycle while the receiver does not stall.
//   Reset: config returns to 640x480 with default colours, no line is active and
//   both pipeline registers are empty.
//   Receiver stall: the result holds, a command is still taken into the pending
//   register if it is empty, then in_ready drops until the receiver takes a result.
`default_nettype none

module bresenham_line_rasterizer_top
    import blr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire line_in_t                 in_data,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output pixel_out_t                    out_data,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    cfg_t  cfg;
    pend_t pend;
    logic  pend_valid;
    logic  pend_ready;

    blr_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    blr_walker u_walker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .pend_valid (pend_valid),
        .pend_ready (pend_ready),
        .pend       (pend)
    );

    blr_pixel u_pixel
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pend_valid (pend_valid),
        .pend_ready (pend_ready),
        .pend       (pend),
        .cfg        (cfg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

// ===== rtl/blr_cfg_regs.sv =====
// Configuration registers of the line rasterizer: frame size and colours.
// Depends on blr_pkg.
`default_nettype none

module blr_cfg_regs
    import blr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                          cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_FRAME_WIDTH:  cfg_next.frame_width  = cfg_data[DIM_BITS-1:0];
                REG_FRAME_HEIGHT: cfg_next.frame_height = cfg_data[DIM_BITS-1:0];
                REG_LINE_COLOR:   cfg_next.line_color   = cfg_data[COLOR_BITS-1:0];
                REG_ALT_COLOR:    cfg_next.alt_color    = cfg_data[COLOR_BITS-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= FRAME_WIDTH_RST;
            cfg_reg.frame_height <= FRAME_HEIGHT_RST;
            cfg_reg.line_color   <= LINE_COLOR_RST;
            cfg_reg.alt_color    <= ALT_COLOR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/blr_walker.sv =====
// Line walker: endpoint setup on load, one midpoint step per step command.
// Holds the walk state and the pending pixel register. Depends on blr_pkg.
`default_nettype none

module blr_walker
    import blr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire line_in_t in_data,
    output logic          pend_valid,
    input  wire logic     pend_ready,
    output pend_t         pend
);

    localparam int W  = COORD_BITS;
    localparam int W1 = COORD_BITS + 1;
    localparam int SW = COORD_BITS + 2;
    localparam int DW = COORD_BITS + 3;
    localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1};

    logic signed [W-1:0]  cur_x_reg, cur_x_next;
    logic signed [W-1:0]  cur_y_reg, cur_y_next;
    logic signed [W-1:0]  stop_coord_reg, stop_coord_next;
    logic signed [DW-1:0] decision_reg, decision_next;
    logic [SW-1:0]        step_straight_reg, step_straight_next;
    logic signed [SW-1:0] step_diagonal_reg, step_diagonal_next;
    logic                 major_is_y_reg, major_is_y_next;
    logic                 minor_down_reg, minor_down_next;
    logic                 active_reg, active_next;
    logic                 color_select_reg, color_select_next;
    logic                 pend_valid_reg, pend_valid_next;
    pend_t                pend_reg, pend_next;

    logic                 accept;
    logic                 swap;
    logic signed [W-1:0]  sx, sy, ex, ey;
    logic signed [W:0]    dx, dy, ndx, ndy;
    logic [W-1:0]         adx, ady, dmaj, dmin;
    logic                 major_y_ld;
    logic                 diag;
    logic signed [W-1:0]  step_x, step_y;
    logic                 done_ld, done_st;

    assign accept   = in_valid && in_ready;
    assign in_ready = !pend_valid_reg || pend_ready;

    always_comb
    begin
        // setup for a load
        swap = !(in_data.start_x < in_data.end_x);
        sx   = swap ? in_data.end_x   : in_data.start_x;
        sy   = swap ? in_data.end_y   : in_data.start_y;
        ex   = swap ? in_data.start_x : in_data.end_x;
        ey   = swap ? in_data.start_y : in_data.end_y;
        dx   = W1'(in_data.end_x) - W1'(in_data.start_x);
        dy   = W1'(in_data.end_y) - W1'(in_data.start_y);
        ndx  = -dx;
        ndy  = -dy;
        adx  = dx[W] ? ndx[W-1:0] : dx[W-1:0];
        ady  = dy[W] ? ndy[W-1:0] : dy[W-1:0];
        major_y_ld = ady > adx;
        dmaj = major_y_ld ? ady : adx;
        dmin = major_y_ld ? adx : ady;
        done_ld = major_y_ld ? (sy == ey) : (sx == ex);

        // one midpoint step
        diag   = !decision_reg[DW-1];
        step_x = cur_x_reg;
        step_y = cur_y_reg;
        if (major_is_y_reg)
        begin
            step_y = minor_down_reg ? cur_y_reg - ONE : cur_y_reg + ONE;
            if (diag)
            begin
                step_x = cur_x_reg + ONE;
            end
        end
        else
        begin
            step_x = cur_x_reg + ONE;
            if (diag)
            begin
                step_y = minor_down_reg ? cur_y_reg - ONE : cur_y_reg + ONE;
            end
        end
        done_st = major_is_y_reg ? (step_y == stop_coord_reg) : (step_x == stop_coord_reg);

        cur_x_next         = cur_x_reg;
        cur_y_next         = cur_y_reg;
        stop_coord_next    = stop_coord_reg;
        decision_next      = decision_reg;
        step_straight_next = step_straight_reg;
        step_diagonal_next = step_diagonal_reg;
        major_is_y_next    = major_is_y_reg;
        minor_down_next    = minor_down_reg;
        active_next        = active_reg;
        color_select_next  = color_select_reg;
        pend_next          = pend_reg;

        if (accept)
        begin
            case (in_data.cmd)
                CMD_LOAD:
                begin
                    cur_x_next         = sx;
                    cur_y_next         = sy;
                    stop_coord_next    = major_y_ld ? ey : ex;
                    decision_next      = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
                    step_straight_next = {1'b0, dmin, 1'b0};
                    step_diagonal_next = $signed({1'b0, dmin, 1'b0}) - $signed({1'b0, dmaj, 1'b0});
                    major_is_y_next    = major_y_ld;
                    minor_down_next    = sy > ey;
                    active_next        = !done_ld;
                    color_select_next  = in_data.use_alt_color;
                    pend_next.x        = sx;
                    pend_next.y        = sy;
                    pend_next.none     = 1'b0;
                    pend_next.done     = done_ld;
                    pend_next.sel      = in_data.use_alt_color;
                end
                CMD_STEP:
                begin
                    if (active_reg)
                    begin
                        cur_x_next    = step_x;
                        cur_y_next    = step_y;
                        decision_next = decision_reg + (diag ? DW'(step_diagonal_reg)
                                                             : $signed({1'b0, step_straight_reg}));
                        active_next   = !done_st;
                        pend_next.x    = step_x;
                        pend_next.y    = step_y;
                        pend_next.none = 1'b0;
                        pend_next.done = done_st;
                        pend_next.sel  = color_select_reg;
                    end
                    else
                    begin
                        pend_next.x    = cur_x_reg;
                        pend_next.y    = cur_y_reg;
                        pend_next.none = 1'b1;
                        pend_next.done = 1'b1;
                        pend_next.sel  = color_select_reg;
                    end
                end
                default:
                begin
                    pend_next = pend_reg;
                end
            endcase
        end

        if (accept)
        begin
            pend_valid_next = 1'b1;
        end
        else if (pend_ready)
        begin
            pend_valid_next = 1'b0;
        end
        else
        begin
            pend_valid_next = pend_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg         <= '0;
            cur_y_reg         <= '0;
            stop_coord_reg    <= '0;
            decision_reg      <= '0;
            step_straight_reg <= '0;
            step_diagonal_reg <= '0;
            major_is_y_reg    <= 1'b0;
            minor_down_reg    <= 1'b0;
            active_reg        <= 1'b0;
            color_select_reg  <= 1'b0;
            pend_valid_reg    <= 1'b0;
        end
        else
        begin
            cur_x_reg         <= cur_x_next;
            cur_y_reg         <= cur_y_next;
            stop_coord_reg    <= stop_coord_next;
            decision_reg      <= decision_next;
            step_straight_reg <= step_straight_next;
            step_diagonal_reg <= step_diagonal_next;
            major_is_y_reg    <= major_is_y_next;
            minor_down_reg    <= minor_down_next;
            active_reg        <= active_next;
            color_select_reg  <= color_select_next;
            pend_valid_reg    <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    assign pend_valid = pend_valid_reg;
    assign pend       = pend_reg;

endmodule

`default_nettype wire

// ===== rtl/blr_pixel.sv =====
// Address stage: frame clipping, x + y*width address, colour pick, result register.
// Depends on blr_pkg.
`default_nettype none

module blr_pixel
    import blr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     pend_valid,
    output logic          pend_ready,
    input  wire pend_t    pend,
    input  wire cfg_t     cfg,
    output logic          out_valid,
    input  wire logic     out_ready,
    output pixel_out_t    out_data
);

    localparam int W  = COORD_BITS;
    localparam int CW = COORD_BITS + DIM_BITS;
    localparam int AW = (CW > ADDR_BITS) ? CW : ADDR_BITS;

    logic          out_valid_reg, out_valid_next;
    pixel_out_t    out_data_reg, out_data_next;

    logic          fire;
    logic [W-1:0]  xu, yu;
    logic          visible;
    logic [CW-1:0] prod;
    logic [AW-1:0] addr;

    assign pend_ready = !out_valid_reg || out_ready;
    assign fire       = pend_valid && pend_ready;

    always_comb
    begin
        xu      = pend.x;
        yu      = pend.y;
        visible = !pend.none && !xu[W-1] && !yu[W-1]
                  && ({{DIM_BITS{1'b0}}, xu} < {{W{1'b0}}, cfg.frame_width})
                  && ({{DIM_BITS{1'b0}}, yu} < {{W{1'b0}}, cfg.frame_height});
        prod    = {{DIM_BITS{1'b0}}, yu} * {{W{1'b0}}, cfg.frame_width};
        addr    = AW'(prod) + AW'(xu);

        out_data_next = out_data_reg;
        if (fire)
        begin
            out_data_next.pixel_valid   = visible;
            out_data_next.pixel_address = visible ? addr[ADDR_BITS-1:0] : '0;
            out_data_next.pixel_color   = !visible ? '0
                                        : (pend.sel ? cfg.alt_color : cfg.line_color);
            out_data_next.line_done     = pend.done;
        end

        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/blr_checker.sv =====
// Port-level checks for the line rasterizer, bound to the top level.
// Depends on blr_pkg and bresenham_line_rasterizer_top.
`default_nettype none

module blr_checker
    import blr_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire pixel_out_t out_data
);

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data);
    endproperty

    property p_clip_zero;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.pixel_valid |->
            out_data.pixel_address == '0 && out_data.pixel_color == '0;
    endproperty

    property p_backpressure;
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready;
    endproperty

    property p_no_gap;
        @(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> ##1 out_valid;
    endproperty

    a_out_hold:     assert property (p_out_hold)     else $error("result changed while stalled");
    a_clip_zero:    assert property (p_clip_zero)    else $error("clipped pixel not zeroed");
    a_backpressure: assert property (p_backpressure) else $error("in_ready low without stall");
    a_no_gap:       assert property (p_no_gap)       else $error("transfer produced no result");

endmodule

bind bresenham_line_rasterizer_top blr_checker u_blr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
